// File: rtl/idct_pkg.sv
// ----------------------------------------------------------------------------
// idct_pkg
// Shared constants and helpers for the 8x8 inverse DCT.
// ----------------------------------------------------------------------------
package idct_pkg;

  localparam int COEF_WIDTH = 12;
  localparam int N = 8;
  localparam int ROW_WIDTH = 32;
  localparam int ACC_WIDTH = 64;
  localparam int WEIGHT_WIDTH = 16;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROW,
    ST_COL
  } state_t;

  function automatic logic signed [WEIGHT_WIDTH-1:0] cos_half(input logic [3:0] k);
    logic signed [WEIGHT_WIDTH-1:0] w;
    case (k)
      4'd0: w = 16'sd8192;
      4'd1: w = 16'sd8035;
      4'd2: w = 16'sd7568;
      4'd3: w = 16'sd6811;
      4'd4: w = 16'sd5793;
      4'd5: w = 16'sd4551;
      4'd6: w = 16'sd3135;
      4'd7: w = 16'sd1598;
      default: w = 16'sd0;
    endcase
    return w;
  endfunction

  // W(x,u) in Q2.13
  function automatic logic signed [WEIGHT_WIDTH-1:0] weight(input logic [2:0] x,
                                                          input logic [2:0] u);
    logic [4:0] k;
    logic [7:0] p;
    logic signed [WEIGHT_WIDTH-1:0] w;
    p = ({4'd0, x, 1'b1} * {5'd0, u});
    k = p[4:0];
    if (k > 5'd16) k = 5'd0 - k;
    if (u == 3'd0) w = 16'sd5793;
    else if (k > 5'd8) w = -cos_half(4'(5'd16 - k));
    else w = cos_half(k[3:0]);
    return w;
  endfunction

endpackage

// File: rtl/inverse_dct_8x8_unit.sv
// ----------------------------------------------------------------------------
// inverse_dct_8x8_unit
// Separable 8x8 inverse DCT with a row of eight MAC cells.
// ----------------------------------------------------------------------------
// Loads 64 coefficients in row-major order, one per cycle. A chain of eight
// MAC cells then runs two passes. The first pass walks each coefficient
// column: feed, chain fill, then one-per-cycle writes of eight sums to the
// intermediate store. The second pass walks each intermediate row: compute,
// then a drain of eight samples, so samples leave in row-major order. Both
// passes are exact integer sums, so their order does not change the result.
// Block throughput is set by the single operand chain that feeds the eight
// cells. Output stalls lengthen the drain. Input is taken again once the last
// sample is in the output register.
module inverse_dct_8x8_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 valid_in,
  output logic                                 ready_in,
  input  logic signed [idct_pkg::COEF_WIDTH-1:0] coefficient,
  output logic                                 valid_out,
  input  logic                                 ready_out,
  output logic signed [7:0]                    sample,
  output logic                                 last_sample
);

  localparam int NC = idct_pkg::N;
  localparam int RW = idct_pkg::ROW_WIDTH;
  localparam int AW = idct_pkg::ACC_WIDTH;

  idct_pkg::state_t state, state_next;

  logic signed [idct_pkg::COEF_WIDTH-1:0] coef_mem [64];
  logic signed [RW-1:0] row_mem [64];

  logic [5:0] load_count;
  logic [2:0] group;   // coefficient column (first pass) or output row (second pass)
  logic [3:0] step;    // 0..7 feed index
  logic       draining;
  logic [2:0] drain_idx;

  logic signed [RW-1:0] coef_rd, row_rd, feed;
  logic signed [RW-1:0] chain [NC+1];
  logic signed [AW-1:0] acc [NC];
  logic signed [AW-1:0] hold [NC];
  logic [2:0] feed_k;
  logic       cell_en, cell_clr;

  assign ready_in = (state == idct_pkg::ST_LOAD);

  always_ff @(posedge clk) begin
    if (valid_in && ready_in) coef_mem[load_count] <= coefficient;
  end

  // operand read: first pass reads coef[k*8+group], second pass reads row[group*8+k]
  always_ff @(posedge clk) begin
    coef_rd <= RW'(coef_mem[{step[2:0], group}]);
    row_rd  <= row_mem[{group, step[2:0]}];
    feed_k  <= step[2:0];
  end

  assign feed = (state == idct_pkg::ST_ROW) ? coef_rd : row_rd;
  assign chain[0] = feed;

  // operand delay per cell index: cell i sees feed k in the cycle after cell i-1 does;
  // weights follow the same per-cell delay
  logic [2:0] k_pipe [NC];
  logic       v_pipe [NC];
  logic       c_pipe [NC];
  logic       feed_v, feed_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_v <= 1'b0;
      for (int i = 0; i < NC; i++) v_pipe[i] <= 1'b0;
    end else begin
      feed_v <= cell_en;
      v_pipe[0] <= feed_v;
      for (int i = 1; i < NC; i++) v_pipe[i] <= v_pipe[i-1];
    end
    feed_c <= cell_clr;
    c_pipe[0] <= feed_c;
    k_pipe[0] <= feed_k;
    for (int i = 1; i < NC; i++) begin
      c_pipe[i] <= c_pipe[i-1];
      k_pipe[i] <= k_pipe[i-1];
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic signed [idct_pkg::WEIGHT_WIDTH-1:0] w;
    logic [2:0] k_here;
    logic       v_here, c_here;
    assign k_here = (i == 0) ? feed_k : k_pipe[(i == 0) ? 0 : i-1];
    assign v_here = (i == 0) ? feed_v : v_pipe[(i == 0) ? 0 : i-1];
    assign c_here = (i == 0) ? feed_c : c_pipe[(i == 0) ? 0 : i-1];
    assign w = (state == idct_pkg::ST_ROW) ? idct_pkg::weight(3'(i), k_here)
                                           : idct_pkg::weight(3'(i), k_here);
    idct_cell u_cell (
      .clk         (clk),
      .clr         (c_here),
      .en          (v_here),
      .operand_in  (chain[i]),
      .weight      (w),
      .operand_out (chain[i+1]),
      .acc         (acc[i])
    );
  end

  // all sums are final from tick 16; the first pass writes one per cycle
  // through tick 23, the second pass latches them at tick 18
  logic [4:0] tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idct_pkg::ST_LOAD;
      load_count <= '0;
      group <= '0;
      tick <= '0;
      draining <= 1'b0;
      drain_idx <= '0;
      valid_out <= 1'b0;
    end else begin
      state <= state_next;
      if (valid_out && ready_out && !(state == idct_pkg::ST_COL && draining))
        valid_out <= 1'b0;
      unique case (state)
        idct_pkg::ST_LOAD: begin
          if (valid_in) begin
            load_count <= load_count + 6'd1;
            if (load_count == 6'd63) begin
              group <= '0;
              tick <= '0;
            end
          end
        end
        idct_pkg::ST_ROW: begin
          if (tick >= 5'd16) row_mem[{tick[2:0], group}] <= RW'(acc[tick[2:0]]);
          if (tick == 5'd23) begin
            tick <= '0;
            group <= group + 3'd1;
          end else begin
            tick <= tick + 5'd1;
          end
        end
        idct_pkg::ST_COL: begin
          if (!draining) begin
            if (tick == 5'd18) begin
              for (int i = 0; i < NC; i++) hold[i] <= acc[i];
              draining <= 1'b1;
              drain_idx <= '0;
              tick <= '0;
            end else begin
              tick <= tick + 5'd1;
            end
          end else if (!valid_out || ready_out) begin
            logic signed [AW-1:0] v;
            v = hold[drain_idx] + (AW'(1) <<< 27);
            if (v >= (AW'(128) <<< 28)) sample <= 8'sd127;
            else if (v < -(AW'(128) <<< 28)) sample <= -8'sd128;
            else sample <= v[35:28];
            last_sample <= (drain_idx == 3'd7) && (group == 3'd7);
            valid_out <= 1'b1;
            drain_idx <= drain_idx + 3'd1;
            if (drain_idx == 3'd7) begin
              draining <= 1'b0;
              group <= group + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // second pass: group is the output row r and cell i is the output column c;
  // every cell sees the intermediate row r and weighs it by W(c,k).

  always_comb begin
    state_next = state;
    cell_en = 1'b0;
    cell_clr = 1'b0;
    step = {1'b0, tick[2:0]};
    unique case (state)
      idct_pkg::ST_LOAD: if (valid_in && load_count == 6'd63) state_next = idct_pkg::ST_ROW;
      idct_pkg::ST_ROW: begin
        cell_en = (tick < 5'd8);
        cell_clr = (tick == 5'd0);
        if (tick == 5'd23 && group == 3'd7) state_next = idct_pkg::ST_COL;
      end
      idct_pkg::ST_COL: begin
        cell_en = !draining && (tick < 5'd8);
        cell_clr = (tick == 5'd0);
        if (draining && drain_idx == 3'd7 && (!valid_out || ready_out) && group == 3'd7)
          state_next = idct_pkg::ST_LOAD;
      end
      default: state_next = idct_pkg::ST_LOAD;
    endcase
  end

endmodule

// File: rtl/idct_cell.sv
// ----------------------------------------------------------------------------
// idct_cell
// One multiply-accumulate cell: owns one intermediate row (first pass) or one
// output column (second pass) and passes its operand to the next cell.
// ----------------------------------------------------------------------------
module idct_cell (
  input  logic                                     clk,
  input  logic                                     clr,
  input  logic                                     en,
  input  logic signed [idct_pkg::ROW_WIDTH-1:0]    operand_in,
  input  logic signed [idct_pkg::WEIGHT_WIDTH-1:0] weight,
  output logic signed [idct_pkg::ROW_WIDTH-1:0]    operand_out,
  output logic signed [idct_pkg::ACC_WIDTH-1:0]    acc
);

  logic signed [idct_pkg::ROW_WIDTH+idct_pkg::WEIGHT_WIDTH-1:0] product;

  assign product = operand_in * weight;

  always_ff @(posedge clk) begin
    if (en) begin
      operand_out <= operand_in;
      if (clr) acc <= idct_pkg::ACC_WIDTH'(product);
      else acc <= acc + idct_pkg::ACC_WIDTH'(product);
    end
  end

endmodule

// File: rtl/idct_checker.sv
// ----------------------------------------------------------------------------
// idct_checker
// Port-level checks for the inverse DCT unit.
// ----------------------------------------------------------------------------
module idct_checker (
  input logic clk,
  input logic rst,
  input logic valid_in,
  input logic ready_in,
  input logic valid_out,
  input logic ready_out,
  input logic signed [7:0] sample,
  input logic last_sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out && $stable(sample))
    else $error("request dropped while stalled");

  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    valid_in && ready_in |-> !valid_out || last_sample)
    else $error("input taken during output");

  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    valid_out && ready_out && last_sample |=> !valid_out)
    else $error("extra request after last sample");

endmodule

bind inverse_dct_8x8_unit idct_checker u_idct_checker (
  .clk(clk), .rst(rst), .valid_in(valid_in), .ready_in(ready_in),
  .valid_out(valid_out), .ready_out(ready_out), .sample(sample),
  .last_sample(last_sample)
);
